// File: sv/pos_pkg.sv
// Shared types and constants for the power-off supervisor.
package pos_pkg;

  localparam int unsigned MS_PER_MINUTE = 60000;
  localparam int unsigned GRACE_RESET   = 5000;
  localparam int unsigned MINUTES_W     = 8;
  localparam int unsigned GRACE_W       = 16;
  localparam int unsigned LIMIT_W       = 24;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_OFF_MINUTES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_GRACE = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_DATA = 2'd1,
    CMD_LINK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_BUTTON   = 2'd1,
    CAUSE_CRITICAL = 2'd2,
    CAUSE_TIMER    = 2'd3
  } cause_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] now_ms;
    logic              connected;
    logic              button_off;
    logic              on_battery;
    logic              battery_present;
    logic              battery_critical;
  } evt_t;

  typedef struct packed {
    logic       show_warning;
    logic [1:0] shutdown_cause;
    logic       armed_flag;
    logic       timer_active;
  } res_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] off_limit_ms;
    logic [GRACE_W-1:0] critical_grace_ms;
  } cfg_t;

endpackage

// File: sv/pos_if.sv
// Event and result channel interfaces of the power-off supervisor.
interface pos_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] now_ms;
  logic        connected;
  logic        button_off;
  logic        on_battery;
  logic        battery_present;
  logic        battery_critical;

  modport source (
    output valid, command, now_ms, connected, button_off, on_battery,
           battery_present, battery_critical,
    input  ready
  );
  modport sink (
    input  valid, command, now_ms, connected, button_off, on_battery,
           battery_present, battery_critical,
    output ready
  );
endinterface

interface pos_res_if;
  logic       valid;
  logic       ready;
  logic       show_warning;
  logic [1:0] shutdown_cause;
  logic       armed_flag;
  logic       timer_active;

  modport source (
    output valid, show_warning, shutdown_cause, armed_flag, timer_active,
    input  ready
  );
  modport sink (
    input  valid, show_warning, shutdown_cause, armed_flag, timer_active,
    output ready
  );
endinterface

// File: sv/pos_cfg.sv
// Configuration registers; the off delay is held as a precomputed limit in ms.
module pos_cfg
  import pos_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic [GRACE_W-1:0] grace_q, grace_d;

  always_comb begin
    limit_d = limit_q;
    grace_d = grace_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFF_MINUTES: begin
          limit_d = LIMIT_W'(cfg_wdata_i[MINUTES_W-1:0]) * LIMIT_W'(MS_PER_MINUTE);
        end
        CFG_CRITICAL_GRACE: begin
          grace_d = cfg_wdata_i[GRACE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      grace_q <= GRACE_W'(GRACE_RESET);
    end else begin
      limit_q <= limit_d;
      grace_q <= grace_d;
    end
  end

  assign cfg_o.off_limit_ms      = limit_q;
  assign cfg_o.critical_grace_ms = grace_q;

endmodule

// File: sv/pos_core.sv
// Supervisor state and per-event decision logic.
module pos_core
  import pos_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  evt_t evt_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  logic              armed_q, armed_d;
  logic              timer_run_q, timer_run_d;
  logic [TIME_W-1:0] timer_start_q, timer_start_d;
  logic              warn_shown_q, warn_shown_d;
  logic [TIME_W-1:0] crit_start_q, crit_start_d;

  logic [TIME_W-1:0] timer_elapsed;
  logic [TIME_W-1:0] crit_elapsed;
  logic              crit_stop;
  logic              warn;
  cause_e            cause;

  assign timer_elapsed = evt_i.now_ms - timer_start_q;
  assign crit_elapsed  = evt_i.now_ms - crit_start_q;

  always_comb begin
    armed_d       = armed_q;
    timer_run_d   = timer_run_q;
    timer_start_d = timer_start_q;
    warn_shown_d  = warn_shown_q;
    crit_start_d  = crit_start_q;
    warn          = 1'b0;
    crit_stop     = 1'b0;
    cause         = CAUSE_NONE;
    unique case (cmd_e'(evt_i.command))
      CMD_TICK: begin
        if (evt_i.button_off) begin
          cause = CAUSE_BUTTON;
        end else begin
          if (evt_i.on_battery && evt_i.battery_present) begin
            if (evt_i.battery_critical) begin
              if (!warn_shown_q) begin
                warn         = 1'b1;
                warn_shown_d = 1'b1;
                crit_start_d = evt_i.now_ms;
              end else if (crit_elapsed > TIME_W'(cfg_i.critical_grace_ms)) begin
                crit_stop = 1'b1;
              end
            end else begin
              warn_shown_d = 1'b0;
            end
          end
          if (crit_stop) begin
            cause = CAUSE_CRITICAL;
          end else if (timer_run_q && (timer_elapsed >= TIME_W'(cfg_i.off_limit_ms))) begin
            timer_run_d = 1'b0;
            cause       = CAUSE_TIMER;
          end
        end
      end
      CMD_DATA: begin
        armed_d = 1'b1;
      end
      CMD_LINK: begin
        if (evt_i.connected) begin
          timer_run_d = 1'b0;
        end else if (armed_q && (cfg_i.off_limit_ms != '0)) begin
          timer_run_d   = 1'b1;
          timer_start_d = evt_i.now_ms;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q       <= 1'b0;
      timer_run_q   <= 1'b0;
      timer_start_q <= '0;
      warn_shown_q  <= 1'b0;
      crit_start_q  <= '0;
    end else if (step_i) begin
      armed_q       <= armed_d;
      timer_run_q   <= timer_run_d;
      timer_start_q <= timer_start_d;
      warn_shown_q  <= warn_shown_d;
      crit_start_q  <= crit_start_d;
    end
  end

  assign res_o.show_warning   = warn;
  assign res_o.shutdown_cause = cause;
  assign res_o.armed_flag     = armed_d;
  assign res_o.timer_active   = timer_run_d;

endmodule

// File: sv/power_off_supervisor_top.sv
// Power-off supervisor top level: event register, decision core, result register.
// A beat passes from the event register through the decision core into the result register.
// Throughput: one event per cycle while the result output is not stalled.
// Input ready drops only while the event register is full and the result is stalled.
// Reset clears all supervisor state; off_minutes resets to 0, critical grace to 5000 ms.
module power_off_supervisor_top
  import pos_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pos_evt_if.sink               evt_i,
  pos_res_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg;
  evt_t evt_q;
  logic evt_vld_q;
  res_t res_q, res_d;
  logic res_vld_q;
  logic advance;
  logic step;
  logic evt_take;

  assign advance   = !res_vld_q || res_o.ready;
  assign step      = evt_vld_q && advance;
  assign evt_i.ready = !evt_vld_q || advance;
  assign evt_take  = evt_i.valid && evt_i.ready;

  pos_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pos_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .evt_i  (evt_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (evt_take) begin
        evt_vld_q <= 1'b1;
      end else if (step) begin
        evt_vld_q <= 1'b0;
      end
      if (step) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_take) begin
      evt_q.command          <= evt_i.command;
      evt_q.now_ms           <= evt_i.now_ms;
      evt_q.connected        <= evt_i.connected;
      evt_q.button_off       <= evt_i.button_off;
      evt_q.on_battery       <= evt_i.on_battery;
      evt_q.battery_present  <= evt_i.battery_present;
      evt_q.battery_critical <= evt_i.battery_critical;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = res_vld_q;
  assign res_o.show_warning   = res_q.show_warning;
  assign res_o.shutdown_cause = res_q.shutdown_cause;
  assign res_o.armed_flag     = res_q.armed_flag;
  assign res_o.timer_active   = res_q.timer_active;

endmodule

// File: sim/power_off_supervisor_top_tb.sv
// Testbench for the power-off supervisor: directed and random events checked against a predictor.
module power_off_supervisor_top_tb;
  import pos_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_COUNT = 6;
  localparam int unsigned PHASE_ITEMS = 255;

  class supervisor_scoreboard;
    logic [MINUTES_W-1:0] minutes_cfg;
    logic [GRACE_W-1:0]   grace_cfg;
    logic                 is_armed;
    logic                 off_timer_on;
    logic [TIME_W-1:0]    off_timer_t0;
    logic                 warned;
    logic [TIME_W-1:0]    critical_t0;
    res_t                 pending_results[$];
    int unsigned          errors;

    function new();
      minutes_cfg  = '0;
      grace_cfg    = GRACE_W'(GRACE_RESET);
      is_armed     = 1'b0;
      off_timer_on = 1'b0;
      off_timer_t0 = '0;
      warned       = 1'b0;
      critical_t0  = '0;
      errors       = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_OFF_MINUTES) begin
        minutes_cfg = value[MINUTES_W-1:0];
      end else begin
        grace_cfg = value[GRACE_W-1:0];
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function cause_e run_tick(evt_t e, output logic warn);
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] limit;
      warn = 1'b0;
      if (e.button_off) return CAUSE_BUTTON;
      if (e.on_battery && e.battery_present) begin
        if (e.battery_critical) begin
          if (!warned) begin
            warn = 1'b1;
            warned = 1'b1;
            critical_t0 = e.now_ms;
          end else if (TIME_W'(e.now_ms - critical_t0) > TIME_W'(grace_cfg)) begin
            return CAUSE_CRITICAL;
          end
        end else begin
          warned = 1'b0;
        end
      end
      if (off_timer_on) begin
        elapsed = e.now_ms - off_timer_t0;
        limit = TIME_W'(minutes_cfg) * MS_PER_MINUTE;
        if (elapsed >= limit) begin
          off_timer_on = 1'b0;
          return CAUSE_TIMER;
        end
      end
      return CAUSE_NONE;
    endfunction

    function void note_event(evt_t e);
      res_t r;
      logic warn;
      r = '0;
      case (e.command)
        CMD_TICK: begin
          r.shutdown_cause = run_tick(e, warn);
          r.show_warning = warn;
        end
        CMD_DATA: begin
          is_armed = 1'b1;
        end
        CMD_LINK: begin
          if (e.connected) begin
            off_timer_on = 1'b0;
          end else if (is_armed && minutes_cfg != 0) begin
            off_timer_on = 1'b1;
            off_timer_t0 = e.now_ms;
          end
        end
        default: begin
        end
      endcase
      r.armed_flag = is_armed;
      r.timer_active = off_timer_on;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 60) $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 60) $display("%0t: result beat with no event pending, actual %p", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("show_warning", 32'(want.show_warning), 32'(got.show_warning));
      compare_field("shutdown_cause", 32'(want.shutdown_cause), 32'(got.shutdown_cause));
      compare_field("armed_flag", 32'(want.armed_flag), 32'(got.armed_flag));
      compare_field("timer_active", 32'(want.timer_active), 32'(got.timer_active));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int unsigned           cycle_count = 0;

  pos_evt_if evt_if ();
  pos_res_if res_if ();

  supervisor_scoreboard sb;

  logic [TIME_W-1:0]    wall_ms;
  logic [MINUTES_W-1:0] cur_minutes;
  logic [GRACE_W-1:0]   cur_grace;
  logic                 batt_level;
  logic                 batt_fitted;
  logic                 batt_low;
  logic [MINUTES_W-1:0] phase_minutes [PHASE_COUNT];
  logic [GRACE_W-1:0]   phase_grace [PHASE_COUNT];
  evt_t                 next_evt;

  power_off_supervisor_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_result({res_if.show_warning, res_if.shutdown_cause, res_if.armed_flag,
                       res_if.timer_active});
    end
  end

  function automatic int unsigned pick_len(int unsigned zero_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      res_if.ready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8))
        @(posedge clk_i);
      res_if.ready <= 1'b0;
      repeat (pick_len(0)) @(posedge clk_i);
    end
  end

  task automatic push_event(evt_t e);
    int unsigned gap;
    gap = pick_len(60);
    if (gap > 0) begin
      evt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt_if.valid            <= 1'b1;
    evt_if.command          <= e.command;
    evt_if.now_ms           <= e.now_ms;
    evt_if.connected        <= e.connected;
    evt_if.button_off       <= e.button_off;
    evt_if.on_battery       <= e.on_battery;
    evt_if.battery_present  <= e.battery_present;
    evt_if.battery_critical <= e.battery_critical;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    sb.note_event(e);
  endtask

  task automatic wait_drained();
    evt_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [MINUTES_W-1:0] minutes, logic [GRACE_W-1:0] grace);
    logic [CFG_DATA_W-1:0] word;
    wait_drained();
    repeat (4) @(posedge clk_i);
    word = {8'($urandom), minutes};
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_OFF_MINUTES;
    cfg_wdata_i <= word;
    @(posedge clk_i);
    sb.set_register(CFG_OFF_MINUTES, word);
    cfg_idx_i   <= CFG_CRITICAL_GRACE;
    cfg_wdata_i <= grace;
    @(posedge clk_i);
    sb.set_register(CFG_CRITICAL_GRACE, grace);
    cfg_we_i <= 1'b0;
    cur_minutes = minutes;
    cur_grace = grace;
  endtask

  // flags: connected, button_off, on_battery, battery_present, battery_critical
  task automatic send_directed(logic [1:0] cmd, logic [TIME_W-1:0] now, logic [4:0] flags);
    evt_t e;
    e.command = cmd;
    e.now_ms = now;
    {e.connected, e.button_off, e.on_battery, e.battery_present, e.battery_critical} = flags;
    push_event(e);
    wall_ms = now;
  endtask

  task automatic random_event(output evt_t e);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 68) e.command = CMD_TICK;
    else if (r < 80) e.command = CMD_DATA;
    else if (r < 95) e.command = CMD_LINK;
    else e.command = CMD_RESERVED;
    r = $urandom_range(0, 99);
    if (r < 50) wall_ms += $urandom_range(0, 1500);
    else if (r < 80) wall_ms += $urandom_range(0, 32'(cur_grace) + 2000);
    else if (r < 96) wall_ms += $urandom_range(0, 32'(cur_minutes) * MS_PER_MINUTE + 60000);
    else wall_ms = $urandom();
    e.now_ms = wall_ms;
    if ($urandom_range(0, 9) == 0) batt_low = ~batt_low;
    if ($urandom_range(0, 14) == 0) batt_level = ~batt_level;
    if ($urandom_range(0, 24) == 0) batt_fitted = ~batt_fitted;
    e.connected = 1'($urandom);
    if (e.command == CMD_TICK) begin
      e.button_off       = ($urandom_range(0, 29) == 0);
      e.on_battery       = batt_level;
      e.battery_present  = batt_fitted;
      e.battery_critical = batt_low;
    end else begin
      {e.button_off, e.on_battery, e.battery_present, e.battery_critical} = 4'($urandom);
    end
  endtask

  initial begin
    sb = new();
    rst_ni                  = 1'b0;
    evt_if.valid            <= 1'b0;
    evt_if.command          <= CMD_TICK;
    evt_if.now_ms           <= '0;
    evt_if.connected        <= 1'b0;
    evt_if.button_off       <= 1'b0;
    evt_if.on_battery       <= 1'b0;
    evt_if.battery_present  <= 1'b0;
    evt_if.battery_critical <= 1'b0;
    cfg_we_i                <= 1'b0;
    cfg_idx_i               <= CFG_OFF_MINUTES;
    cfg_wdata_i             <= '0;
    cur_minutes = '0;
    cur_grace = GRACE_W'(GRACE_RESET);
    batt_level = 1'b1;
    batt_fitted = 1'b1;
    batt_low = 1'($urandom);
    phase_minutes[0] = 8'd0;   phase_grace[0] = 16'd0;
    phase_minutes[1] = 8'd1;   phase_grace[1] = 16'd5000;
    phase_minutes[2] = 8'd255; phase_grace[2] = 16'hFFFF;
    phase_minutes[3] = 8'd2;   phase_grace[3] = 16'($urandom);
    phase_minutes[4] = 8'($urandom_range(1, 255)); phase_grace[4] = 16'($urandom_range(0, 300));
    phase_minutes[5] = 8'd1;   phase_grace[5] = 16'd1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: timer disabled, default grace
    send_directed(CMD_TICK, 32'd0, 5'b00000);
    send_directed(CMD_DATA, 32'd0, 5'b00000);
    send_directed(CMD_LINK, 32'd10, 5'b00000);
    send_directed(CMD_TICK, 32'd1000, 5'b00111);
    send_directed(CMD_TICK, 32'd6000, 5'b00111);
    send_directed(CMD_TICK, 32'd6001, 5'b00111);
    send_directed(CMD_TICK, 32'd6002, 5'b00110);

    apply_settings(8'd1, 16'd100);
    send_directed(CMD_LINK, 32'd0, 5'b00000);
    send_directed(CMD_TICK, 32'd59999, 5'b00000);
    send_directed(CMD_TICK, 32'd60000, 5'b00000);
    send_directed(CMD_LINK, 32'hFFFF_FFF0, 5'b00000);
    send_directed(CMD_LINK, 32'hFFFF_FFFF, 5'b00000);
    send_directed(CMD_TICK, 32'd59998, 5'b00000);
    send_directed(CMD_LINK, 32'd59998, 5'b10000);
    send_directed(CMD_TICK, 32'd59999, 5'b00000);
    send_directed(CMD_LINK, 32'd100, 5'b00000);
    send_directed(CMD_TICK, 32'd200, 5'b01111);
    send_directed(CMD_TICK, 32'd200, 5'b00111);
    send_directed(CMD_TICK, 32'd300, 5'b00111);
    send_directed(CMD_TICK, 32'd301, 5'b00111);
    send_directed(CMD_TICK, 32'd60100, 5'b00011);
    send_directed(CMD_RESERVED, 32'hFFFF_FFFF, 5'b11111);
    send_directed(CMD_TICK, 32'hFFFF_FFFF, 5'b10101);
    send_directed(CMD_LINK, 32'd500, 5'b00000);

    // timer still runs into the first phase, where a zero delay expires it at once
    for (int p = 0; p < PHASE_COUNT; p++) begin
      apply_settings(phase_minutes[p], phase_grace[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 120) wait_drained();
        random_event(next_evt);
        push_event(next_evt);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
